[src/vsm_pkg.sv]
// Package for the vector softmax block: payload types, constants and helpers.
package vsm_pkg;

  localparam int MaxLen = 64;
  localparam int AddrW = 6;
  localparam int CntW = 7;
  localparam int ScoreW = 16;
  localparam int SumW = 40;
  localparam int QuotW = 17;

  typedef struct packed {
    logic signed [15:0] score;
    logic last_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] probability;
    logic [5:0] position;
    logic last_out;
  } out_item_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_MAX,
    S_SUM,
    S_EXP,
    S_DIV,
    S_OUT
  } state_t;

  // 65536 * 2^(-j/16), rounded.
  function automatic logic [16:0] pow2_neg(input logic [4:0] j);
    logic [16:0] v;
    begin
      case (j)
        5'd0: v = 17'd65536;
        5'd1: v = 17'd62757;
        5'd2: v = 17'd60097;
        5'd3: v = 17'd57549;
        5'd4: v = 17'd55109;
        5'd5: v = 17'd52773;
        5'd6: v = 17'd50535;
        5'd7: v = 17'd48393;
        5'd8: v = 17'd46341;
        5'd9: v = 17'd44376;
        5'd10: v = 17'd42495;
        5'd11: v = 17'd40693;
        5'd12: v = 17'd38968;
        5'd13: v = 17'd37316;
        5'd14: v = 17'd35734;
        5'd15: v = 17'd34219;
        default: v = 17'd32768;
      endcase
      return v;
    end
  endfunction

endpackage

[src/vsm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module vsm_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/vsm_exp.sv]
// Two-stage exp(-t) unit: scale by log2(e), then table interpolation and shift.
module vsm_exp (
  input  logic        clk,
  input  logic [15:0] t,
  output logic [16:0] e
);

  logic [33:0] prod;
  logic [25:0] y;
  logic [9:0]  k;
  logic [3:0]  s;
  logic [11:0] r;
  logic [16:0] ta;
  logic [16:0] tb;
  logic [28:0] dr;
  logic [16:0] g;

  always_ff @(posedge clk) begin
    y <= 26'(prod >> 8);
  end

  always_comb begin
    prod = {18'd0, t} * 34'd94548;
    k = y[25:16];
    s = y[15:12];
    r = y[11:0];
    ta = vsm_pkg::pow2_neg({1'b0, s});
    tb = vsm_pkg::pow2_neg(5'({1'b0, s} + 5'd1));
    dr = (ta - tb) * r;
    g = ta - 17'(dr >> 12);
  end

  always_ff @(posedge clk) begin
    e <= (k >= 10'd32) ? 17'd0 : (g >> k[4:0]);
  end

endmodule

[src/vsm_div.sv]
// Restoring divider: (e * 65536 + sum / 2) / sum, one quotient bit a cycle.
module vsm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] e,
  input  logic [39:0] sum,
  output logic        done,
  output logic [15:0] quot
);

  logic [40:0] rem;
  logic [32:0] num;
  logic [16:0] q;
  logic [5:0]  cnt;
  logic        busy;
  logic [40:0] trial;

  assign trial = {rem[39:0], num[32]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 6'd1);
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd33;
        rem <= '0;
        q <= '0;
        num <= {e, 16'd0} + 33'(sum >> 1);
      end else if (busy) begin
        num <= {num[31:0], 1'b0};
        if (trial >= {1'b0, sum}) begin
          rem <= trial - {1'b0, sum};
          q <= {q[15:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[15:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Upper quotient bits beyond 17 are zero since e <= 65536 and sum >= 65536.
  assign quot = q[16] ? 16'hFFFF : q[15:0];

endmodule

[src/vector_softmax.sv]
// Top level of the vector softmax block.
// Scores are taken one per cycle into a 64-entry score memory while the block
// is loading; the transfer that carries last_in ends the vector. The block then
// stops taking scores and runs three passes over the memory: a maximum search,
// a sum of exponentials through the two-stage exponential unit, and an emit
// pass in which each element is read again, its exponential recomputed and
// divided by the sum in a bit-serial divider. The maximum search and the sum
// each run at one memory read a cycle. The emit pass handles one element at a
// time: the element is read and its exponential formed, the divider is started
// and produces its 33 quotient bits, and the quotient is held in the output
// register. The divider sets the emit rate. Each probability waits in the
// output register until its transfer completes, and no score is taken until
// the last probability of the vector has gone. Scores beyond 64 are dropped,
// but last_in still ends the vector.
module vector_softmax (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  vsm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vsm_pkg::out_item_t result
);

  vsm_pkg::state_t state;
  vsm_pkg::state_t state_next;

  logic [vsm_pkg::CntW-1:0]  count;
  logic [vsm_pkg::CntW-1:0]  ridx;    // read address issued
  logic [vsm_pkg::CntW-1:0]  pidx;    // element being processed in emit pass
  logic [2:0]                pipe;    // valid shift for read + exp latency
  logic signed [15:0]        top;
  logic [vsm_pkg::SumW-1:0]  exp_sum;
  logic [15:0]               rdata;
  logic [15:0]               t_in;
  logic [16:0]               e;
  logic                      div_done;
  logic [15:0]               quot;
  logic                      div_start;
  logic                      in_acc;
  logic                      we;
  logic [vsm_pkg::AddrW-1:0] raddr;

  assign in_acc = in_valid && !in_stall;
  assign we = in_acc && (count < vsm_pkg::CntW'(vsm_pkg::MaxLen));
  assign raddr = ridx[vsm_pkg::AddrW-1:0];
  assign t_in = 16'(top - $signed(rdata));

  vsm_ram #(.Width(vsm_pkg::ScoreW), .Depth(vsm_pkg::MaxLen)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count[vsm_pkg::AddrW-1:0]),
    .wdata (in_data.score),
    .raddr (raddr),
    .rdata (rdata)
  );

  vsm_exp u_exp (
    .clk (clk),
    .t   (t_in),
    .e   (e)
  );

  vsm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .e     (e),
    .sum   (exp_sum),
    .done  (div_done),
    .quot  (quot)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      vsm_pkg::S_LOAD: if (in_acc && in_data.last_in) state_next = vsm_pkg::S_MAX;
      vsm_pkg::S_MAX:  if (!pipe[0] && ridx >= count) state_next = vsm_pkg::S_SUM;
      vsm_pkg::S_SUM:  if (pipe == 3'b000 && ridx >= count) state_next = vsm_pkg::S_EXP;
      vsm_pkg::S_EXP:  if (pipe[2]) state_next = vsm_pkg::S_DIV;
      vsm_pkg::S_DIV:  if (div_done) state_next = vsm_pkg::S_OUT;
      vsm_pkg::S_OUT: begin
        if (!out_stall) begin
          state_next = (pidx + 7'd1 >= count) ? vsm_pkg::S_LOAD : vsm_pkg::S_EXP;
        end
      end
      default: state_next = vsm_pkg::S_LOAD;
    endcase
  end

  // Output logic.
  always_comb begin
    in_stall = (state != vsm_pkg::S_LOAD);
    out_valid = (state == vsm_pkg::S_OUT);
    div_start = (state == vsm_pkg::S_EXP) && pipe[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vsm_pkg::S_LOAD;
      count <= '0;
      ridx <= '0;
      pidx <= '0;
      pipe <= '0;
      exp_sum <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        vsm_pkg::S_LOAD: begin
          // Every pass starts its reads after the last write, the first in the cycle
          // after it, so a read never meets the write of the same entry.
          if (we) count <= count + 7'd1;
          ridx <= '0;
          pipe <= '0;
        end
        vsm_pkg::S_MAX: begin
          // rdata holds entry ridx - 1 whenever pipe[0] is set.
          if (state_next == vsm_pkg::S_SUM) begin
            ridx <= '0;
            pipe <= '0;
            exp_sum <= '0;
          end else begin
            if (pipe[0] && (ridx == 7'd1 || $signed(rdata) > top)) begin
              top <= $signed(rdata);
            end
            pipe <= {2'b00, (ridx < count)};
            if (ridx < count) ridx <= ridx + 7'd1;
          end
        end
        vsm_pkg::S_SUM: begin
          // pipe[0] rdata valid, pipe[1] exp stage 1, pipe[2] exp result.
          if (state_next == vsm_pkg::S_EXP) begin
            ridx <= '0;
            pidx <= '0;
            pipe <= '0;
          end else begin
            if (pipe[2]) exp_sum <= exp_sum + 40'(e);
            pipe <= {pipe[1:0], (ridx < count)};
            if (ridx < count) ridx <= ridx + 7'd1;
          end
        end
        vsm_pkg::S_EXP: begin
          // The read of the element is issued on the first cycle; pipe then tracks the
          // read data and the two exponential stages until the exponential is ready.
          pipe <= {pipe[1:0], (pipe == 3'b000)};
        end
        vsm_pkg::S_DIV: begin
          if (div_done) result.probability <= quot;
          result.position <= pidx[vsm_pkg::AddrW-1:0];
          result.last_out <= (pidx + 7'd1 == count);
        end
        vsm_pkg::S_OUT: begin
          if (!out_stall) begin
            if (pidx + 7'd1 >= count) begin
              count <= '0;
            end else begin
              pidx <= pidx + 7'd1;
              ridx <= ridx + 7'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[test/tb_vector_softmax.sv]
// Testbench for vector_softmax: directed and random vectors checked against a softmax predictor.
module tb_vector_softmax;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected probabilities of each vector, kept in order and compared with every
  // output transfer as it completes.
  class softmax_scoreboard;
    logic [15:0] scores[$];
    vsm_pkg::out_item_t pending[$];
    int errors;

    function logic [16:0] pow2_lut(input logic [4:0] j);
      logic [16:0] lut[17];
      lut = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
              44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
      return lut[j];
    endfunction

    function logic [16:0] exp_neg(input logic [16:0] t);
      logic [39:0] y;
      logic [23:0] k;
      logic [15:0] f;
      logic [16:0] ts, tn;
      logic [31:0] g;
      y = ({23'd0, t} * 40'd94548) >> 8;
      k = y[39:16];
      f = y[15:0];
      ts = pow2_lut({1'b0, f[15:12]});
      tn = pow2_lut({1'b0, f[15:12]} + 5'd1);
      g = ts - (((ts - tn) * f[11:0]) >> 12);
      if (k >= 32) return 17'd0;
      return 17'(g >> k);
    endfunction

    function void note_score(vsm_pkg::in_item_t it);
      int top, n;
      logic [39:0] sum;
      logic [63:0] p;
      vsm_pkg::out_item_t r;
      if (scores.size() < vsm_pkg::MaxLen) scores.push_back(it.score);
      if (!it.last_in) return;
      n = scores.size();
      top = $signed(scores[0]);
      foreach (scores[i]) if ($signed(scores[i]) > top) top = $signed(scores[i]);
      sum = 0;
      foreach (scores[i]) sum += exp_neg(17'(top - $signed(scores[i])));
      for (int i = 0; i < n; i++) begin
        p = ({47'd0, exp_neg(17'(top - $signed(scores[i])))} << 16);
        p = (p + sum / 2) / sum;
        r.probability = (p > 65535) ? 16'hFFFF : p[15:0];
        r.position = i[5:0];
        r.last_out = (i == n - 1);
        pending.push_back(r);
      end
      scores.delete();
    endfunction

    function void check_result(vsm_pkg::out_item_t got);
      vsm_pkg::out_item_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  vsm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  vsm_pkg::out_item_t result;

  softmax_scoreboard board = new();
  int idle_cycles = 0;
  int sent_count = 0;
  bit stalls_on = 1;

  vector_softmax DUT (.*);

  always #10 clk = ~clk;

  // Completed transfers are seen at the rising edge, before any driving there.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) board.note_score(in_data);
    if (!rst && out_valid && !out_stall) board.check_result(result);
    if (!rst && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // The receiver stalls on its own pattern: stretches of heavy stall, light
  // stall and none at all, switched at random.
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= stalls_on && ($urandom_range(0, 3) == 0);
      default: out_stall <= stalls_on && ($urandom_range(0, 3) != 0);
    endcase
  end

  // Watchdog: a long vector runs its passes with no transfer on the input, and
  // heavy stalls stretch that time further.
  always @(posedge clk) begin
    if (idle_cycles > 20000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // One score transfer; holds the payload until it is taken.
  task automatic send_score(input logic [15:0] s, input logic fin);
    in_valid <= 1;
    in_data.score <= s;
    in_data.last_in <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic gap();
    int g;
    g = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // A vector of a given length with a chosen spread of scores; oversize
  // vectors exercise the full store.
  task automatic send_vector(input int len, input int spread);
    logic [15:0] s;
    int base;
    base = $urandom_range(0, 65535);
    for (int i = 0; i < len; i++) begin
      if (spread == 0) s = 16'($urandom);
      else s = 16'(base + $urandom_range(0, spread));
      send_score(s, i == len - 1);
      gap();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: single elements, extremes, equal scores, mixed signs.
    send_score(16'h7FFF, 1);
    send_score(16'h8000, 1);
    send_score(16'h8000, 0);
    send_score(16'h7FFF, 1);
    send_score(16'h0000, 0);
    send_score(16'h0000, 0);
    send_score(16'h0000, 1);
    send_score(16'h0100, 0);
    send_score(16'hFF00, 0);
    send_score(16'h5555, 0);
    send_score(16'hAAAA, 1);
    gap();
    // Store full: 70 scores, the last ones dropped.
    send_vector(70, 300);
    while (sent_count < 370) begin
      case ($urandom_range(0, 3))
        0: send_vector($urandom_range(1, 4), 0);
        1: send_vector($urandom_range(2, 12), $urandom_range(0, 2000));
        2: send_vector($urandom_range(2, 20), 0);
        default: send_vector($urandom_range(1, 8), $urandom_range(0, 40));
      endcase
      gap();
    end
    in_valid <= 0;
    // Let the monitor take the final input transfer before waiting on results.
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    stalls_on = 0;
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
